// ===== hw/rtl/stt_pkg.sv =====
// Types, token codes and character-class helpers for the source text tokenizer.
package stt_pkg;

    localparam int POS_WIDTH = 16;
    localparam logic [POS_WIDTH-1:0] POS_MAX = {POS_WIDTH{1'b1}};

    // token kinds
    localparam logic [4:0] KIND_IDENT = 5'd0;
    localparam logic [4:0] KIND_INT   = 5'd1;
    localparam logic [4:0] KIND_STR   = 5'd2;
    localparam logic [4:0] KIND_LPAR  = 5'd3;
    localparam logic [4:0] KIND_RPAR  = 5'd4;
    localparam logic [4:0] KIND_SEMI  = 5'd5;
    localparam logic [4:0] KIND_LBRC  = 5'd6;
    localparam logic [4:0] KIND_RBRC  = 5'd7;
    localparam logic [4:0] KIND_LBRK  = 5'd8;
    localparam logic [4:0] KIND_RBRK  = 5'd9;
    localparam logic [4:0] KIND_ASSN  = 5'd10;
    localparam logic [4:0] KIND_PLUS  = 5'd11;
    localparam logic [4:0] KIND_MINUS = 5'd12;
    localparam logic [4:0] KIND_STAR  = 5'd13;
    localparam logic [4:0] KIND_SLASH = 5'd14;
    localparam logic [4:0] KIND_COLON = 5'd15;
    localparam logic [4:0] KIND_EOF   = 5'd16;
    localparam logic [4:0] KIND_ERR   = 5'd17;

    // characters with special handling
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_UNDER = 8'h5F;

    // "EOF" is three characters long
    localparam logic [POS_WIDTH-1:0] EOF_LENGTH = POS_WIDTH'(3);

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } t_in_item;

    typedef struct packed {
        logic [4:0]           token_code;
        logic [POS_WIDTH-1:0] start_row;
        logic [POS_WIDTH-1:0] start_column;
        logic [POS_WIDTH-1:0] token_length;
        logic                 last_of_run;
    } t_out_item;

    function automatic logic is_letter(input logic [7:0] b);
        return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A) || b == CH_UNDER;
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return b >= 8'h30 && b <= 8'h39;
    endfunction

    function automatic logic [POS_WIDTH-1:0] sat_inc(input logic [POS_WIDTH-1:0] v);
        return (v == POS_MAX) ? POS_MAX : v + POS_WIDTH'(1);
    endfunction

    // single-character operators; anything else is an error token
    function automatic logic [4:0] op_kind(input logic [7:0] b);
        logic [4:0] k;
        unique case (b)
            8'h28:   k = KIND_LPAR;
            8'h29:   k = KIND_RPAR;
            8'h3B:   k = KIND_SEMI;
            8'h7B:   k = KIND_LBRC;
            8'h7D:   k = KIND_RBRC;
            8'h5B:   k = KIND_LBRK;
            8'h5D:   k = KIND_RBRK;
            8'h3D:   k = KIND_ASSN;
            8'h2B:   k = KIND_PLUS;
            8'h2D:   k = KIND_MINUS;
            8'h2A:   k = KIND_STAR;
            8'h2F:   k = KIND_SLASH;
            8'h3A:   k = KIND_COLON;
            default: k = KIND_ERR;
        endcase
        return k;
    endfunction

endpackage

// ===== hw/rtl/source_text_tokenizer_top.sv =====
// Byte-serial tokenizer: scan state, token formation and output queue.
//
// Takes one source byte or end-of-text marker per cycle while o_in_ready is
// high and produces tokens with start row, start column and length. Each
// accepted request updates the scan state in the same cycle and writes its
// zero, one or two tokens into a four-entry output queue; a token reaches
// the output once those ahead of it have drained. The output side drains
// one token per cycle while i_out_ready is high, so a steady byte stream
// runs at one byte per cycle as long as bytes give at most one token each;
// a byte that closes a pending identifier or integer and is an operator
// or unknown symbol, and end-of-text with a pending token, queue two tokens.
// o_in_ready drops while fewer than two queue slots are free. Row, column
// and length saturate at all ones; after EOF the scanner returns to its
// reset state, ready for a new text. No keyword flagging, no lexeme.
module source_text_tokenizer_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  stt_pkg::t_in_item i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output stt_pkg::t_out_item o_out_data
);

    localparam int PW = stt_pkg::POS_WIDTH;

    // scan modes
    localparam logic [1:0] MODE_IDLE  = 2'd0;
    localparam logic [1:0] MODE_IDENT = 2'd1;
    localparam logic [1:0] MODE_INT   = 2'd2;
    localparam logic [1:0] MODE_STR   = 2'd3;

    // output queue geometry
    localparam int QDEPTH = 4;
    localparam int PTR_W  = $clog2(QDEPTH);
    localparam int CNT_W  = $clog2(QDEPTH + 1);

    // scan state
    logic [1:0]    r_mode, n_mode;
    logic [PW-1:0] r_row, n_row;
    logic [PW-1:0] r_col, n_col;
    logic [PW-1:0] r_psr, n_psr;
    logic [PW-1:0] r_psc, n_psc;
    logic [PW-1:0] r_plen, n_plen;

    // output queue
    stt_pkg::t_out_item r_q [QDEPTH];
    logic [PTR_W-1:0]   r_wp, r_rp;
    logic [CNT_W-1:0]   r_count, n_count;

    logic       accept_in, accept_out;
    logic [7:0] b;
    logic       flush_v, main_v;
    stt_pkg::t_out_item flush_t, main_t, e0, e1;
    logic [1:0] n_tokens;

    assign accept_in  = i_in_valid && o_in_ready;
    assign accept_out = o_out_valid && i_out_ready;
    assign b          = i_in_data.text_byte;

    // Two token slots per request: a flush of the pending token, then the
    // token that the byte itself produces (operator, error, string, EOF).
    always_comb begin
        n_mode  = r_mode;
        n_row   = r_row;
        n_col   = r_col;
        n_psr   = r_psr;
        n_psc   = r_psc;
        n_plen  = r_plen;
        flush_v = 1'b0;
        main_v  = 1'b0;
        flush_t = '{token_code: stt_pkg::KIND_IDENT, start_row: r_psr,
                    start_column: r_psc, token_length: r_plen, last_of_run: 1'b0};
        main_t  = '{token_code: stt_pkg::KIND_ERR, start_row: r_row,
                    start_column: r_col, token_length: PW'(1), last_of_run: 1'b0};

        if (i_in_data.end_of_text) begin
            // flush whatever is pending; an open string is an error
            flush_v = (r_mode != MODE_IDLE);
            if (r_mode == MODE_INT) begin
                flush_t.token_code = stt_pkg::KIND_INT;
            end else if (r_mode == MODE_STR) begin
                flush_t.token_code = stt_pkg::KIND_ERR;
            end
            main_v              = 1'b1;
            main_t.token_code   = stt_pkg::KIND_EOF;
            main_t.token_length = stt_pkg::EOF_LENGTH;
            n_mode = MODE_IDLE;
            n_row  = PW'(1);
            n_col  = PW'(1);
            n_psr  = PW'(1);
            n_psc  = PW'(1);
            n_plen = '0;
        end else if (r_mode == MODE_STR) begin
            // newline inside a string is content: column advances, row holds
            if (b == stt_pkg::CH_QUOTE) begin
                main_v = 1'b1;
                main_t = '{token_code: stt_pkg::KIND_STR, start_row: r_psr,
                           start_column: r_psc, token_length: r_plen,
                           last_of_run: 1'b0};
                n_mode = MODE_IDLE;
                n_plen = '0;
            end else begin
                n_plen = stt_pkg::sat_inc(r_plen);
            end
            n_col = stt_pkg::sat_inc(r_col);
        end else if ((r_mode == MODE_IDENT &&
                      (stt_pkg::is_letter(b) || stt_pkg::is_digit(b))) ||
                     (r_mode == MODE_INT && stt_pkg::is_digit(b))) begin
            n_plen = stt_pkg::sat_inc(r_plen);
            n_col  = stt_pkg::sat_inc(r_col);
        end else begin
            // run ends here: emit it, then treat the byte as from idle
            if (r_mode == MODE_IDENT || r_mode == MODE_INT) begin
                flush_v = 1'b1;
                if (r_mode == MODE_INT) begin
                    flush_t.token_code = stt_pkg::KIND_INT;
                end
                n_mode = MODE_IDLE;
                n_plen = '0;
            end
            if (b == stt_pkg::CH_SPACE || b == stt_pkg::CH_TAB) begin
                n_col = stt_pkg::sat_inc(r_col);
            end else if (b == stt_pkg::CH_NL) begin
                n_row = stt_pkg::sat_inc(r_row);
                n_col = PW'(1);
            end else if (stt_pkg::is_letter(b)) begin
                n_mode = MODE_IDENT;
                n_psr  = r_row;
                n_psc  = r_col;
                n_plen = PW'(1);
                n_col  = stt_pkg::sat_inc(r_col);
            end else if (stt_pkg::is_digit(b)) begin
                n_mode = MODE_INT;
                n_psr  = r_row;
                n_psc  = r_col;
                n_plen = PW'(1);
                n_col  = stt_pkg::sat_inc(r_col);
            end else if (b == stt_pkg::CH_QUOTE) begin
                n_mode = MODE_STR;
                n_psr  = r_row;
                n_psc  = r_col;
                n_plen = '0;
                n_col  = stt_pkg::sat_inc(r_col);
            end else begin
                main_v            = 1'b1;
                main_t.token_code = stt_pkg::op_kind(b);
                n_col             = stt_pkg::sat_inc(r_col);
            end
        end

        // pack into queue order and mark the last token of the request
        e0 = flush_v ? flush_t : main_t;
        e1 = main_t;
        if (flush_v && main_v) begin
            e1.last_of_run = 1'b1;
        end else begin
            e0.last_of_run = 1'b1;
        end
        n_tokens = {1'b0, flush_v} + {1'b0, main_v};
    end

    always_comb begin
        n_count = r_count;
        if (accept_in) begin
            n_count = n_count + CNT_W'(n_tokens);
        end
        if (accept_out) begin
            n_count = n_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_row   <= PW'(1);
            r_col   <= PW'(1);
            r_psr   <= PW'(1);
            r_psc   <= PW'(1);
            r_plen  <= '0;
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (accept_in) begin
                r_mode <= n_mode;
                r_row  <= n_row;
                r_col  <= n_col;
                r_psr  <= n_psr;
                r_psc  <= n_psc;
                r_plen <= n_plen;
                r_wp   <= r_wp + PTR_W'(n_tokens);
            end
            if (accept_out) begin
                r_rp <= r_rp + PTR_W'(1);
            end
            r_count <= n_count;
        end
    end

    // queue payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (accept_in && n_tokens != 2'd0) begin
            r_q[r_wp] <= e0;
            if (n_tokens == 2'd2) begin
                r_q[r_wp + PTR_W'(1)] <= e1;
            end
        end
    end

    // room for the worst case of two tokens per request
    assign o_in_ready  = (r_count <= CNT_W'(QDEPTH - 2));
    assign o_out_valid = (r_count != '0);
    assign o_out_data  = r_q[r_rp];

endmodule

// ===== tb/sv/source_text_tokenizer_top_test.sv =====
// Self-checking testbench for the source text tokenizer top level.
module source_text_tokenizer_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    // Scanner modes of the local token predictor.
    typedef enum logic [1:0] {
        SCAN_IDLE,
        SCAN_IDENT,
        SCAN_INT,
        SCAN_STR
    } t_scan_mode;

    localparam int PW = stt_pkg::POS_WIDTH;
    localparam logic [7:0] CH_APOS = 8'h27;
    // All thirteen single-character operators, one per byte.
    localparam logic [13*8-1:0] OP_TEXT = "(){}[];=+-*/:";
    localparam int NUM_OPS = 13;
    localparam int RANDOM_ITEMS = 360;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    stt_pkg::t_in_item  i_in_data;
    logic               o_out_valid;
    logic               i_out_ready;
    stt_pkg::t_out_item o_out_data;

    source_text_tokenizer_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Token predictor state: position of the next byte and the token
    // being collected (identifier, integer or open string).
    // ------------------------------------------------------------------
    t_scan_mode    scan_mode;
    logic [PW-1:0] row_at;
    logic [PW-1:0] col_at;
    logic [PW-1:0] tok_row;
    logic [PW-1:0] tok_col;
    logic [PW-1:0] tok_len;

    stt_pkg::t_out_item expected_tokens[$];   // tokens owed by the block, oldest first
    int                 mismatch_count;
    int                 requests_sent;
    bit                 throttle;             // 0: no gaps on either side
    int                 ready_hold;
    stt_pkg::t_out_item want_token;

    // saturating +1 at the position width
    function automatic logic [PW-1:0] bump(input logic [PW-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic logic letter_byte(input logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == stt_pkg::CH_UNDER;
    endfunction

    function automatic logic digit_byte(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic stt_pkg::t_out_item make_token(input logic [4:0] kind,
                                                      input logic [PW-1:0] r,
                                                      input logic [PW-1:0] c,
                                                      input logic [PW-1:0] len);
        stt_pkg::t_out_item t;
        t.token_code   = kind;
        t.start_row    = r;
        t.start_column = c;
        t.token_length = len;
        t.last_of_run  = 1'b0;
        return t;
    endfunction

    // Kind of the pending token when it is flushed; an open string is an error.
    function automatic logic [4:0] pending_kind();
        case (scan_mode)
            SCAN_IDENT: return stt_pkg::KIND_IDENT;
            SCAN_INT:   return stt_pkg::KIND_INT;
            default:    return stt_pkg::KIND_ERR;
        endcase
    endfunction

    task automatic clear_scan();
        scan_mode = SCAN_IDLE;
        row_at    = PW'(1);
        col_at    = PW'(1);
        tok_row   = PW'(1);
        tok_col   = PW'(1);
        tok_len   = '0;
    endtask

    task automatic start_run(input t_scan_mode mode, input logic [PW-1:0] len);
        scan_mode = mode;
        tok_row   = row_at;
        tok_col   = col_at;
        tok_len   = len;
        col_at    = bump(col_at);
    endtask

    // Advance the scanner by one accepted request and queue its tokens.
    task automatic predict_tokens(input stt_pkg::t_in_item req);
        stt_pkg::t_out_item toks[2];
        int                 n;
        logic [7:0]         b;
        logic [4:0]         kind;
        n = 0;
        b = req.text_byte;
        if (req.end_of_text) begin
            if (scan_mode != SCAN_IDLE) begin
                toks[n] = make_token(pending_kind(), tok_row, tok_col, tok_len);
                n++;
            end
            toks[n] = make_token(stt_pkg::KIND_EOF, row_at, col_at, stt_pkg::EOF_LENGTH);
            n++;
            clear_scan();
        end else if (scan_mode == SCAN_STR) begin
            // everything up to the closing quote belongs to the string, newline too
            if (b == stt_pkg::CH_QUOTE) begin
                toks[n] = make_token(stt_pkg::KIND_STR, tok_row, tok_col, tok_len);
                n++;
                scan_mode = SCAN_IDLE;
                tok_len   = '0;
            end else begin
                tok_len = bump(tok_len);
            end
            col_at = bump(col_at);
        end else if ((scan_mode == SCAN_IDENT && (letter_byte(b) || digit_byte(b))) ||
                     (scan_mode == SCAN_INT && digit_byte(b))) begin
            tok_len = bump(tok_len);
            col_at  = bump(col_at);
        end else begin
            // run ends here; the byte is then scanned from idle
            if (scan_mode != SCAN_IDLE) begin
                toks[n] = make_token(pending_kind(), tok_row, tok_col, tok_len);
                n++;
                scan_mode = SCAN_IDLE;
                tok_len   = '0;
            end
            if (b == stt_pkg::CH_SPACE || b == stt_pkg::CH_TAB) begin
                col_at = bump(col_at);
            end else if (b == stt_pkg::CH_NL) begin
                row_at = bump(row_at);
                col_at = PW'(1);
            end else if (letter_byte(b)) begin
                start_run(SCAN_IDENT, PW'(1));
            end else if (digit_byte(b)) begin
                start_run(SCAN_INT, PW'(1));
            end else if (b == stt_pkg::CH_QUOTE) begin
                start_run(SCAN_STR, '0);
            end else begin
                case (b)
                    "(":     kind = stt_pkg::KIND_LPAR;
                    ")":     kind = stt_pkg::KIND_RPAR;
                    ";":     kind = stt_pkg::KIND_SEMI;
                    "{":     kind = stt_pkg::KIND_LBRC;
                    "}":     kind = stt_pkg::KIND_RBRC;
                    "[":     kind = stt_pkg::KIND_LBRK;
                    "]":     kind = stt_pkg::KIND_RBRK;
                    "=":     kind = stt_pkg::KIND_ASSN;
                    "+":     kind = stt_pkg::KIND_PLUS;
                    "-":     kind = stt_pkg::KIND_MINUS;
                    "*":     kind = stt_pkg::KIND_STAR;
                    "/":     kind = stt_pkg::KIND_SLASH;
                    ":":     kind = stt_pkg::KIND_COLON;
                    default: kind = stt_pkg::KIND_ERR;   // apostrophe and unknown bytes
                endcase
                toks[n] = make_token(kind, row_at, col_at, PW'(1));
                n++;
                col_at = bump(col_at);
            end
        end
        if (n > 0) begin
            toks[n-1].last_of_run = 1'b1;
        end
        for (int i = 0; i < n; i++) begin
            expected_tokens.push_back(toks[i]);
        end
    endtask

    // ------------------------------------------------------------------
    // Idle gaps: mostly none or short, a few long; off when throttle is 0.
    // ------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        if (!throttle) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    // Output side stalls.
    always @(negedge i_clk) begin
        if (ready_hold > 0) begin
            ready_hold--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
            ready_hold = pick_gap();
        end
    end

    // ------------------------------------------------------------------
    // Request driver. Valid stays up between back-to-back requests and is
    // only lowered for a gap or a drain, so it never sees two updates in
    // one step.
    // ------------------------------------------------------------------
    task automatic send_request(input logic [7:0] b, input logic eot);
        stt_pkg::t_in_item req;
        int                gap;
        req.text_byte   = b;
        req.end_of_text = eot;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        do @(posedge i_clk); while (!o_in_ready);
        predict_tokens(req);
        requests_sent++;
    endtask

    // end of text; the byte field is don't-care, so it carries noise
    task automatic send_end();
        send_request(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_request(s[i], 1'b0);
        end
    endtask

    // drop valid so the last request is not taken again, then drain
    task automatic wait_all_tokens();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_tokens.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [7:0] random_word_byte();
        int r;
        r = $urandom_range(0, 62);
        if (r < 26) begin
            return 8'("a" + r);
        end else if (r < 52) begin
            return 8'("A" + r - 26);
        end else if (r < 62) begin
            return 8'("0" + r - 52);
        end
        return stt_pkg::CH_UNDER;
    endfunction

    // ------------------------------------------------------------------
    // Result checker: every token against the oldest expectation.
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 100) begin
            $display("ERROR @%0t: %s", $time, msg);
        end
    endtask

    task automatic compare_field(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s: got %0d, expected %0d", field, got, want));
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_tokens.size() == 0) begin
                report_mismatch($sformatf("unexpected token, kind %0d",
                                          o_out_data.token_code));
            end else begin
                want_token = expected_tokens.pop_front();
                compare_field("token_code", 32'(o_out_data.token_code),
                              32'(want_token.token_code));
                compare_field("start_row", 32'(o_out_data.start_row),
                              32'(want_token.start_row));
                compare_field("start_column", 32'(o_out_data.start_column),
                              32'(want_token.start_column));
                compare_field("token_length", 32'(o_out_data.token_length),
                              32'(want_token.token_length));
                compare_field("last_of_run", 32'(o_out_data.last_of_run),
                              32'(want_token.last_of_run));
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // every operator, the apostrophe and the byte extremes as unknown symbols
    task automatic test_single_symbols();
        for (int i = 0; i < NUM_OPS; i++) begin
            send_request(OP_TEXT[i*8 +: 8], 1'b0);
        end
        send_request(CH_APOS, 1'b0);
        send_request(8'h00, 1'b0);
        send_request(8'hFF, 1'b0);
        send_end();
    endtask

    // identifier with underscore and digit, integer cut short by a letter,
    // space, tab and newline, and an integer still open at end of text
    task automatic test_words_and_spacing();
        send_text("_9 7Z\t\n42");
        send_end();
    endtask

    // newline inside a string, then a string left open at end of text
    task automatic test_strings();
        send_text("\"a\n\"\"x");
        send_end();
    endtask

    // one lexeme of random content; mostly well formed, some noise
    task automatic send_random_lexeme();
        int         r;
        logic [7:0] b;
        r = $urandom_range(0, 99);
        if (r < 25) begin
            send_request(8'($urandom_range(0, 1) ? "_" : "a" + $urandom_range(0, 25)), 1'b0);
            repeat ($urandom_range(0, 7)) send_request(random_word_byte(), 1'b0);
        end else if (r < 40) begin
            repeat ($urandom_range(1, 5)) send_request(8'("0" + $urandom_range(0, 9)), 1'b0);
        end else if (r < 52) begin
            send_request(stt_pkg::CH_QUOTE, 1'b0);
            repeat ($urandom_range(0, 6)) begin
                b = ($urandom_range(0, 4) == 0) ? stt_pkg::CH_NL : 8'($urandom_range(0, 255));
                send_request((b == stt_pkg::CH_QUOTE) ? CH_APOS : b, 1'b0);
            end
            // sometimes leave the string open
            if ($urandom_range(0, 5) != 0) begin
                send_request(stt_pkg::CH_QUOTE, 1'b0);
            end
        end else if (r < 72) begin
            send_request(OP_TEXT[$urandom_range(0, NUM_OPS-1)*8 +: 8], 1'b0);
        end else if (r < 85) begin
            send_request($urandom_range(0, 1) ? stt_pkg::CH_SPACE : stt_pkg::CH_TAB, 1'b0);
        end else if (r < 90) begin
            send_request(stt_pkg::CH_NL, 1'b0);
        end else if (r < 93) begin
            send_request(CH_APOS, 1'b0);
        end else begin
            send_request(8'($urandom_range(0, 255)), 1'b0);
        end
    endtask

    // Random texts in chunks; each chunk picks idling on or off, may end
    // the text, and sometimes waits for all tokens before going on.
    task automatic test_random_text();
        int first;
        int chunk;
        first = requests_sent;
        chunk = 0;
        while (requests_sent - first < RANDOM_ITEMS) begin
            throttle = ($urandom_range(0, 4) != 0);
            repeat ($urandom_range(3, 12)) send_random_lexeme();
            if ($urandom_range(0, 3) == 0) begin
                send_end();
            end
            // hold off until the block has drained (forced once)
            if (chunk == 4 || $urandom_range(0, 5) == 0) begin
                wait_all_tokens();
            end
            chunk++;
        end
        throttle = 1'b1;
        send_end();
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_in_data      = '0;
        i_out_ready    = 1'b0;
        ready_hold     = 0;
        throttle       = 1'b1;
        mismatch_count = 0;
        requests_sent  = 0;
        clear_scan();

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_single_symbols();
        test_words_and_spacing();
        test_strings();
        test_random_text();

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        wait_all_tokens();
        // keep the clock running to catch stray tokens
        repeat (16) @(posedge i_clk);

        if (mismatch_count == 0 && expected_tokens.size() == 0) begin
            $display("source_text_tokenizer_top test passed");
        end else begin
            $display("source_text_tokenizer_top test failed");
        end
        $finish;
    end

    // watchdog, well beyond the slowest legal run
    initial begin
        #2000000;
        $display("source_text_tokenizer_top test failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/stt_pkg.sv
hw/rtl/source_text_tokenizer_top.sv
tb/sv/source_text_tokenizer_top_test.sv
